[rtl/core/grc_pkg.sv]
// Shared constants, types and functions of the grid ray-cast column unit.
package grc_pkg;

  localparam int unsigned AngleBits  = 12;
  localparam int unsigned QuarterW   = AngleBits - 2;
  localparam int unsigned Quarter    = 1 << QuarterW;
  localparam int unsigned GridDim    = 16;
  localparam int unsigned ScreenW    = 960;
  localparam int unsigned ScreenH    = 600;
  localparam int unsigned TexW       = 400;
  localparam int unsigned StartDist  = 82;
  localparam int unsigned HeightNum  = 480;
  localparam int unsigned HeightCap  = ScreenH * 13 / 10;
  localparam int unsigned HalfScreen = ScreenH / 2;
  localparam int unsigned ShadeTop   = 190;
  localparam int unsigned ShadeFloor = 19;
  localparam int unsigned DistMax    = 131071;
  localparam int unsigned FieldHalf  = (1 << AngleBits) / 12;
  localparam int unsigned ShareDen   = 6 * ScreenW;
  // Column share 4096 * col / 5760 = 32 * col / 45, as (col * ceil(2^20 / 45)) >> 15;
  // exact for every 10-bit column
  localparam int unsigned ShareMul   = 23302;
  localparam int unsigned ShareShift = 15;
  localparam int unsigned DivW       = 22;
  localparam int unsigned SineOne    = 16384;

  // Configuration register indexes
  localparam logic [1:0] RegStep  = 2'd0;
  localparam logic [1:0] RegLimit = 2'd1;
  localparam logic [1:0] RegCols  = 2'd2;
  localparam logic [1:0] RegRows  = 2'd3;

  typedef logic [15:0] sine_rom_t [Quarter];

  // Quarter-wave sine in Q1.14, from a ten-term Taylor series in Q30
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] theta;
    logic [63:0] t2;
    logic [63:0] term;
    longint      sum;
    longint      e;
    for (int i = 0; i < Quarter; i++) begin
      theta = 64'd1686629713 * 64'(i) / 64'(Quarter);
      t2    = (theta * theta) >> 30;
      term  = theta;
      sum   = longint'(theta);
      for (int k = 1; k <= 9; k++) begin
        term = ((term * t2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if ((k % 2) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      e = (sum + 32768) >>> 16;
      if (e > SineOne) e = SineOne;
      rom[i] = 16'(e);
    end
    return rom;
  endfunction

  // Table address for a binary angle (mirrored in odd quadrants)
  function automatic logic [QuarterW-1:0] sine_addr(input logic [AngleBits-1:0] ang);
    return ang[QuarterW] ? (QuarterW'(0) - ang[QuarterW-1:0]) : ang[QuarterW-1:0];
  endfunction

  // Signed sine from the table word and the angle it was read for
  function automatic logic signed [15:0] sine_fix(input logic [15:0] rom,
                                                  input logic [AngleBits-1:0] ang);
    logic [15:0] m;
    m = (ang[QuarterW] && (ang[QuarterW-1:0] == '0)) ? 16'(SineOne) : rom;
    return ang[AngleBits-1] ? -$signed(m) : $signed(m);
  endfunction

endpackage

[rtl/core/grid_raycast_column_unit.sv]
// Top level of the grid ray-cast column unit: sequencer, divider and shared multiplier.
module grid_raycast_column_unit import grc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [16:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 mode_i,
  input  logic [3:0]           row_index_i,
  input  logic [15:0]          row_walls_i,
  input  logic [15:0]          pos_x_i,
  input  logic [15:0]          pos_y_i,
  input  logic [11:0]          view_angle_i,
  input  logic [9:0]           column_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [16:0]          perp_distance_o,
  output logic [9:0]           wall_height_o,
  output logic signed [9:0]    wall_top_o,
  output logic [8:0]           tex_column_o,
  output logic [7:0]           shade_o,
  output logic                 hit_wall_o
);
  // A row load (mode 0) is written into the grid when it is taken. A cast marches one
  // step per cycle, up to (march_limit - 83) / march_step + 1 steps when march_limit
  // exceeds 82 and none otherwise, and uses one bit-serial division (wall height),
  // three sine table reads and seven passes through one 19x19 multiplier (column share
  // by reciprocal among them). The unit takes no new item during a cast and is idle
  // again once the result is in the output register; a finished result waits in the
  // output register while the next item is taken. Configuration writes are always
  // accepted and are meant for idle times.

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_ANGLE, ST_TRIG_C, ST_TRIG_S, ST_TRIG_CD,
    ST_MUL_PX, ST_MUL_PY, ST_MUL_CS, ST_MUL_SS, ST_MARCH, ST_DIST,
    ST_TEX, ST_FIN
  } state_e;

  localparam sine_rom_t SineRom = build_sine_rom();

  state_e state_q;

  // configuration
  logic [11:0] step_q;
  logic [16:0] limit_q;
  logic [4:0]  cols_q, rows_q;

  logic [15:0] grid_q [GridDim];

  // item and working registers
  logic [15:0]            px_q, py_q;
  logic [AngleBits-1:0]   view_q, diff_q, ray_q, rd_ang_q;
  logic [QuarterW-1:0]    rom_addr;
  logic [15:0]            rom_q;
  logic signed [15:0]     c_q, s_q, cd_q;
  logic [DivW-1:0]        div_num_q;
  logic [16:0]            div_den_q;
  logic [17:0]            div_rem_q;
  logic [4:0]             div_cnt_q;
  logic signed [18:0]     mul_a, mul_b;
  logic signed [37:0]     mul_p_q;
  logic signed [33:0]     pxa_q, pya_q, cstep_q, sstep_q;
  logic [17:0]            d_q;
  logic                   hit_q;
  logic [16:0]            q_q;
  logic [8:0]             tex_q;

  // output register
  logic        out_valid_q;
  logic [16:0] perp_q;
  logic [9:0]  hh_q;
  logic [9:0]  top_q;
  logic [8:0]  texo_q;
  logic [7:0]  shade_q;
  logic        hito_q;
  logic        fin_take;

  // Divider step
  logic [17:0] rem_sh;
  logic        div_bit;
  assign rem_sh  = {div_rem_q[16:0], div_num_q[DivW-1]};
  assign div_bit = rem_sh >= {1'b0, div_den_q};

  // Angles; the column share comes from the product taken with the item
  logic [9:0]           share;
  logic [AngleBits-1:0] ang_diff, ang_ray;
  assign share    = mul_p_q[ShareShift +: 10];
  assign ang_diff = AngleBits'(share) - AngleBits'(FieldHalf);
  assign ang_ray  = view_q + ang_diff;

  // Current ray point and wall test
  logic signed [19:0] hx, hy;
  logic signed [7:0]  ix, iy;
  logic [4:0]         cols_eff, rows_eff;
  logic               is_wall, advance;
  assign hx = $signed({4'b0, px_q}) + pxa_q[33:14];
  assign hy = $signed({4'b0, py_q}) + pya_q[33:14];
  assign ix = hx[19:12];
  assign iy = hy[19:12];
  assign cols_eff = (cols_q > 5'(GridDim)) ? 5'(GridDim) : cols_q;
  assign rows_eff = (rows_q > 5'(GridDim)) ? 5'(GridDim) : rows_q;
  assign is_wall = ix[7] || iy[7] || (ix >= $signed({3'b0, cols_eff}))
                   || (iy >= $signed({3'b0, rows_eff}))
                   || grid_q[iy[3:0]][ix[3:0]];
  assign advance = (d_q < {1'b0, limit_q}) && !is_wall;

  // Texture fraction: along y when the ray runs mostly in x
  logic [15:0] abs_c, abs_s;
  logic [11:0] frac;
  assign abs_c = c_q[15] ? 16'(-c_q) : 16'(c_q);
  assign abs_s = s_q[15] ? 16'(-s_q) : 16'(s_q);
  assign frac  = (abs_c > abs_s) ? hy[11:0] : hx[11:0];

  // Perpendicular distance clamp
  logic signed [23:0] q_raw;
  logic [16:0]        q_clamp;
  assign q_raw   = mul_p_q[37:14];
  assign q_clamp = q_raw[23] ? 17'd0 :
                   (q_raw > 24'sd131071) ? 17'(DistMax) : q_raw[16:0];

  // Final fields
  logic [9:0]         hh;
  logic [10:0]        hh_inc;
  logic signed [10:0] top;
  logic [21:0]        q17;
  logic signed [23:0] shade_v;
  logic [7:0]         shade;
  assign hh      = (div_num_q > DivW'(HeightCap)) ? 10'(HeightCap) : div_num_q[9:0];
  assign hh_inc  = {1'b0, hh} + 11'd1;
  assign top     = 11'(HalfScreen) - $signed({1'b0, hh_inc[10:1]});
  assign q17     = {1'b0, q_q, 4'b0} + {5'b0, q_q};
  assign shade_v = 24'(ShadeTop * 4096) - $signed({2'b0, q17});
  assign shade   = (shade_v < 24'sd77824) ? 8'(ShadeFloor) : shade_v[19:12];

  // Operand and table address selection
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    rom_addr = '0;
    unique case (state_q)
      ST_IDLE:    begin mul_a = $signed({9'b0, column_i}); mul_b = 19'(ShareMul); end
      ST_ANGLE:   rom_addr = sine_addr(ang_ray + AngleBits'(Quarter));
      ST_TRIG_C:  rom_addr = sine_addr(ray_q);
      ST_TRIG_S:  rom_addr = sine_addr(diff_q + AngleBits'(Quarter));
      ST_TRIG_CD: begin mul_a = 19'(c_q); mul_b = 19'(StartDist); end
      ST_MUL_PX:  begin mul_a = 19'(s_q); mul_b = 19'(StartDist); end
      ST_MUL_PY:  begin mul_a = 19'(c_q); mul_b = $signed({7'b0, step_q}); end
      ST_MUL_CS:  begin mul_a = 19'(s_q); mul_b = $signed({7'b0, step_q}); end
      ST_MARCH:   begin mul_a = $signed({1'b0, d_q}); mul_b = 19'(cd_q); end
      ST_DIST:    begin mul_a = $signed({7'b0, frac}); mul_b = 19'(TexW); end
      default: ;
    endcase
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign cfg_ready_o = 1'b1;
  assign fin_take    = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  // Configuration and wall grid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= 12'd74;
      limit_q <= 17'd73728;
      cols_q  <= 5'd16;
      rows_q  <= 5'd9;
      for (int i = 0; i < GridDim; i++) grid_q[i] <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegStep:  step_q  <= cfg_data_i[11:0];
          RegLimit: limit_q <= cfg_data_i;
          RegCols:  cols_q  <= cfg_data_i[4:0];
          RegRows:  rows_q  <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o && !mode_i) grid_q[row_index_i] <= row_walls_i;
    end
  end

  // Sine table and multiplier, registered
  always_ff @(posedge clk_i) begin
    rom_q   <= SineRom[rom_addr];
    mul_p_q <= mul_a * mul_b;
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (fin_take) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && mode_i) begin
            px_q    <= pos_x_i;
            py_q    <= pos_y_i;
            view_q  <= view_angle_i;
            state_q <= ST_ANGLE;
          end
        end
        ST_DIV: begin
          div_rem_q <= div_bit ? (rem_sh - {1'b0, div_den_q}) : rem_sh;
          div_num_q <= {div_num_q[DivW-2:0], div_bit};
          div_cnt_q <= div_cnt_q + 5'd1;
          if (div_cnt_q == 5'(DivW - 1)) state_q <= ST_FIN;
        end
        ST_ANGLE: begin
          diff_q   <= ang_diff;
          ray_q    <= ang_ray;
          rd_ang_q <= ang_ray + AngleBits'(Quarter);
          state_q  <= ST_TRIG_C;
        end
        ST_TRIG_C: begin
          c_q      <= sine_fix(rom_q, rd_ang_q);
          rd_ang_q <= ray_q;
          state_q  <= ST_TRIG_S;
        end
        ST_TRIG_S: begin
          s_q      <= sine_fix(rom_q, rd_ang_q);
          rd_ang_q <= diff_q + AngleBits'(Quarter);
          state_q  <= ST_TRIG_CD;
        end
        ST_TRIG_CD: begin
          cd_q    <= sine_fix(rom_q, rd_ang_q);
          state_q <= ST_MUL_PX;
        end
        ST_MUL_PX: begin
          pxa_q   <= mul_p_q[33:0];
          state_q <= ST_MUL_PY;
        end
        ST_MUL_PY: begin
          pya_q   <= mul_p_q[33:0];
          state_q <= ST_MUL_CS;
        end
        ST_MUL_CS: begin
          cstep_q <= mul_p_q[33:0];
          state_q <= ST_MUL_SS;
        end
        ST_MUL_SS: begin
          sstep_q <= mul_p_q[33:0];
          d_q     <= 18'(StartDist);
          state_q <= ST_MARCH;
        end
        // one march step per cycle
        ST_MARCH: begin
          if (advance) begin
            d_q   <= d_q + {6'b0, step_q};
            pxa_q <= pxa_q + cstep_q;
            pya_q <= pya_q + sstep_q;
          end else begin
            hit_q   <= d_q < {1'b0, limit_q};
            state_q <= ST_DIST;
          end
        end
        ST_DIST: begin
          q_q     <= q_clamp;
          state_q <= ST_TEX;
        end
        ST_TEX: begin
          tex_q     <= (mul_p_q[37:12] > 26'(TexW - 1)) ? 9'(TexW - 1) : mul_p_q[20:12];
          // zero distance gives an all-ones quotient, so the cap applies
          div_num_q <= DivW'(HeightNum * 4096);
          div_den_q <= q_q;
          div_rem_q <= '0;
          div_cnt_q <= '0;
          state_q   <= ST_DIV;
        end
        ST_FIN: begin
          if (fin_take) begin
            perp_q  <= q_q;
            hh_q    <= hh;
            top_q   <= top[9:0];
            texo_q  <= tex_q;
            shade_q <= shade;
            hito_q  <= hit_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign perp_distance_o = perp_q;
  assign wall_height_o   = hh_q;
  assign wall_top_o      = $signed(top_q);
  assign tex_column_o    = texo_q;
  assign shade_o         = shade_q;
  assign hit_wall_o      = hito_q;

  // Checks
  a_out_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (wall_height_o <= 10'(HeightCap)) && (tex_column_o <= 9'(TexW - 1))
                    && (shade_o >= 8'(ShadeFloor)))
    else $error("result field out of range");

  a_top_height: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (11'(signed'(wall_top_o)) ==
                     11'(HalfScreen) - 11'((11'(wall_height_o) + 11'd1) >> 1)))
    else $error("wall top does not match wall height");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_cnt_q < 5'(DivW)))
    else $error("divider ran past its last bit");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench of the grid ray-cast column unit.
`timescale 1ns / 1ps

module tb_top;
  import grc_pkg::*;

  typedef struct packed {
    logic [16:0]       perp;
    logic [9:0]        height;
    logic signed [9:0] top;
    logic [8:0]        tex;
    logic [7:0]        shade;
    logic              hit;
  } slice_t;

  localparam int unsigned StallLimit = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = RegStep;
  logic [16:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        mode_i = 1'b0;
  logic [3:0]  row_index_i = '0;
  logic [15:0] row_walls_i = '0;
  logic [15:0] pos_x_i = '0;
  logic [15:0] pos_y_i = '0;
  logic [11:0] view_angle_i = '0;
  logic [9:0]  column_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [16:0] perp_distance_o;
  logic [9:0]  wall_height_o;
  logic signed [9:0] wall_top_o;
  logic [8:0]  tex_column_o;
  logic [7:0]  shade_o;
  logic        hit_wall_o;

  // Predictor state
  logic [15:0] sine_q14 [Quarter];
  logic [15:0] grid_rows_m [GridDim];
  logic [11:0] step_m;
  logic [16:0] limit_m;
  logic [4:0]  cols_m;
  logic [4:0]  rows_m;

  slice_t      expected_slices [$];
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_on = 1'b1;

  grid_raycast_column_unit DUT (.*);

  // Clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Quarter-wave sine table, Q1.14 by series expansion in Q30
  function automatic void fill_sine();
    logic [63:0] theta, t2, term;
    longint      acc, e;
    for (int i = 0; i < Quarter; i++) begin
      theta = 64'd1686629713 * 64'(i) / 64'(Quarter);
      t2    = (theta * theta) >> 30;
      term  = theta;
      acc   = longint'(theta);
      for (int k = 1; k <= 9; k++) begin
        term = ((term * t2) >> 30) / 64'((2 * k) * (2 * k + 1));
        acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      e = (acc + 32768) >>> 16;
      if (e > SineOne) e = SineOne;
      sine_q14[i] = 16'(e);
    end
  endfunction

  function automatic longint sine_at(logic [11:0] a);
    logic [9:0] r;
    longint     m;
    r = a[9:0];
    if (a[10]) m = (r == 0) ? SineOne : longint'(sine_q14[Quarter - r]);
    else m = longint'(sine_q14[r]);
    return a[11] ? -m : m;
  endfunction

  function automatic bit cell_is_wall(longint px, longint py);
    longint ix, iy, nc, nr;
    ix = px >>> 12;
    iy = py >>> 12;
    nc = (cols_m > GridDim) ? GridDim : cols_m;
    nr = (rows_m > GridDim) ? GridDim : rows_m;
    if (ix < 0 || iy < 0 || ix >= nc || iy >= nr) return 1'b1;
    return grid_rows_m[iy][ix];
  endfunction

  // Expected slice of one cast
  function automatic slice_t cast_ray(logic [15:0] px, logic [15:0] py,
                                      logic [11:0] va, logic [9:0] col);
    slice_t      r;
    longint      share, c, s, cd, d, hx, hy, q, frac, tx, hh, v;
    logic [11:0] diff, ray;
    share = longint'(4096) * longint'(col) / ShareDen;
    diff  = 12'(share - FieldHalf);
    ray   = va + diff;
    c     = sine_at(ray + 12'd1024);
    s     = sine_at(ray);
    d     = StartDist;
    hx    = longint'(px) + ((c * d) >>> 14);
    hy    = longint'(py) + ((s * d) >>> 14);
    while (d < longint'(limit_m) && !cell_is_wall(hx, hy)) begin
      d  = d + longint'(step_m);
      hx = longint'(px) + ((c * d) >>> 14);
      hy = longint'(py) + ((s * d) >>> 14);
    end
    r.hit = d < longint'(limit_m);
    cd = sine_at(diff + 12'd1024);
    q  = (d * cd) >>> 14;
    if (q < 0) q = 0;
    if (q > DistMax) q = DistMax;
    frac = ((c < 0 ? -c : c) > (s < 0 ? -s : s)) ? (hy & 4095) : (hx & 4095);
    tx = (frac * TexW) >> 12;
    if (tx > TexW - 1) tx = TexW - 1;
    hh = HeightCap;
    if (q > 0 && longint'(HeightNum) * 4096 / q < hh) hh = longint'(HeightNum) * 4096 / q;
    v = longint'(ShadeTop) * 4096 - 17 * q;
    r.perp   = 17'(q);
    r.height = 10'(hh);
    r.top    = 10'(longint'(HalfScreen) - (hh + 1) / 2);
    r.tex    = 9'(tx);
    r.shade  = (v < longint'(ShadeFloor) * 4096) ? 8'(ShadeFloor) : 8'(v >>> 12);
    return r;
  endfunction

  // Result ready, idling at random
  always @(posedge clk_i) begin
    out_ready_i <= idle_on ? ($urandom_range(99) >= 34) : 1'b1;
  end

  // Result checker and stall watchdog
  always @(posedge clk_i) begin
    slice_t want;
    if ((in_valid_i && in_ready_o) || (cfg_valid_i && cfg_ready_o)
        || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_slices.size() == 0) begin
        $display("%0t: result with nothing expected: dist %0d", $time, perp_distance_o);
        errors++;
      end else begin
        want = expected_slices.pop_front();
        if (perp_distance_o !== want.perp) begin
          $display("%0t: perp_distance exp %0d act %0d", $time, want.perp, perp_distance_o);
          errors++;
        end
        if (wall_height_o !== want.height) begin
          $display("%0t: wall_height exp %0d act %0d", $time, want.height, wall_height_o);
          errors++;
        end
        if (wall_top_o !== want.top) begin
          $display("%0t: wall_top exp %0d act %0d", $time, want.top, wall_top_o);
          errors++;
        end
        if (tex_column_o !== want.tex) begin
          $display("%0t: tex_column exp %0d act %0d", $time, want.tex, tex_column_o);
          errors++;
        end
        if (shade_o !== want.shade) begin
          $display("%0t: shade exp %0d act %0d", $time, want.shade, shade_o);
          errors++;
        end
        if (hit_wall_o !== want.hit) begin
          $display("%0t: hit_wall exp %0d act %0d", $time, want.hit, hit_wall_o);
          errors++;
        end
      end
    end
  end

  // Send one item; valid stays high if the next item follows at once
  task automatic send_item(bit md, logic [3:0] ri, logic [15:0] rw, logic [15:0] px,
                           logic [15:0] py, logic [11:0] va, logic [9:0] col);
    if (idle_on && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 34);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= md;
    row_index_i  <= ri;
    row_walls_i  <= rw;
    pos_x_i      <= px;
    pos_y_i      <= py;
    view_angle_i <= va;
    column_i     <= col;
    do @(posedge clk_i); while (!in_ready_o);
    if (!md) grid_rows_m[ri] = rw;
    else expected_slices.push_back(cast_ray(px, py, va, col));
  endtask

  task automatic load_row(logic [3:0] ri, logic [15:0] rw);
    send_item(1'b0, ri, rw, 16'($urandom), 16'($urandom), 12'($urandom), 10'($urandom));
  endtask

  task automatic cast(logic [15:0] px, logic [15:0] py, logic [11:0] va, logic [9:0] col);
    send_item(1'b1, 4'($urandom), 16'($urandom), px, py, va, col);
  endtask

  // Lower valid, wait for every result and let a trailing load settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_slices.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegStep:  step_m  = val[11:0];
      RegLimit: limit_m = val;
      RegCols:  cols_m  = val[4:0];
      default:  rows_m  = val[4:0];
    endcase
  endtask

  task automatic set_config(logic [11:0] st, logic [16:0] lim, logic [4:0] nc, logic [4:0] nr);
    write_reg(RegStep, 17'(st));
    write_reg(RegLimit, lim);
    write_reg(RegCols, 17'(nc));
    write_reg(RegRows, 17'(nr));
  endtask

  // Reset configuration, empty grid, angle and position extremes
  task automatic test_reset_state();
    cast(16'h8000, 16'h4800, 12'd0, 10'd480);
    cast(16'h0000, 16'h0000, 12'd1024, 10'd0);
    cast(16'hFFFF, 16'hFFFF, 12'd2048, 10'd959);
    cast(16'h1800, 16'h2000, 12'd3072, 10'd1023);
    cast(16'h7777, 16'h3333, 12'd4095, 10'd500);
    drain();
  endtask

  // Walls, standing inside a wall, far column, ignored-free row loads
  task automatic test_walls();
    load_row(4'd15, 16'hFFFF);
    load_row(4'd0, 16'hFFFF);
    load_row(4'd4, 16'h8001);
    load_row(4'd3, 16'h0000);
    cast(16'h4800, 16'h4800, 12'd0, 10'd480);
    cast(16'h0800, 16'h0800, 12'd512, 10'd100);
    cast(16'h8000, 16'h3800, 12'd3072, 10'd1023);
    cast(16'h2000, 16'h2800, 12'd2500, 10'd0);
    drain();
  endtask

  // Step, limit and grid size extremes
  task automatic test_extremes();
    set_config(12'd4095, 17'd131071, 5'd16, 5'd16);
    cast(16'h0800, 16'h8000, 12'd0, 10'd480);
    cast(16'h8000, 16'h8000, 12'd1000, 10'd700);
    set_config(12'd1, 17'd3000, 5'd31, 5'd31);
    cast(16'h8000, 16'h8000, 12'd300, 10'd480);
    cast(16'h1000, 16'hE000, 12'd2000, 10'd10);
    set_config(12'd200, 17'd1, 5'd0, 5'd0);
    cast(16'h8000, 16'h8000, 12'd0, 10'd480);
    set_config(12'd74, 17'd82, 5'd1, 5'd1);
    cast(16'h0800, 16'h0800, 12'd0, 10'd480);
    set_config(12'd100, 17'd131071, 5'd0, 5'd16);
    cast(16'h0800, 16'h0800, 12'd0, 10'd480);
    drain();
  endtask

  // Random grids and settings, mostly viewers inside the used grid
  task automatic test_random();
    int unsigned nc, nr, lim, st;
    for (int ph = 0; ph < 10; ph++) begin
      idle_on = (ph != 4);
      st  = (ph % 3 == 0) ? $urandom_range(4095, 16) : $urandom_range(120, 16);
      lim = (ph % 4 == 0) ? 131071 : $urandom_range(131071, 1);
      nc  = (ph == 7) ? 20 : $urandom_range(16, 2);
      nr  = (ph == 8) ? 31 : $urandom_range(16, 2);
      set_config(12'(st), 17'(lim), 5'(nc), 5'(nr));
      for (int r = 0; r < 16; r++) load_row(4'(r), 16'($urandom) & 16'($urandom));
      for (int n = 0; n < 40; n++) begin
        if ($urandom_range(9) == 0) load_row(4'($urandom), 16'($urandom));
        else if ($urandom_range(9) == 0)
          cast(16'($urandom), 16'($urandom), 12'($urandom), 10'($urandom));
        else
          cast(16'($urandom_range((nc > 16 ? 16 : nc) * 4096 - 1)),
               16'($urandom_range((nr > 16 ? 16 : nr) * 4096 - 1)),
               12'($urandom), 10'($urandom_range(959)));
      end
    end
    idle_on = 1'b1;
    drain();
  endtask

  initial begin
    fill_sine();
    foreach (grid_rows_m[i]) grid_rows_m[i] = '0;
    step_m  = 12'd74;
    limit_m = 17'd73728;
    cols_m  = 5'd16;
    rows_m  = 5'd9;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_walls();
    test_extremes();
    test_random();
    repeat (2000) @(posedge clk_i);
    if (errors == 0 && expected_slices.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
